### rtl/msci_pkg.sv
// ----------------------------------------------------------------------------
// msci_pkg
// Shared types, opcodes and helpers for the sequence command interpreter.
// ----------------------------------------------------------------------------
`default_nettype none

package msci_pkg;

  // Configuration register indexes
  localparam logic CFG_VARIANT = 1'b0;
  localparam logic CFG_CHANNEL = 1'b1;

  // Command opcodes
  localparam logic [7:0] NOTE_MAX     = 8'h7E;
  localparam logic [7:0] OP_REST      = 8'h7F;
  localparam logic [7:0] OP_SYS_BASE  = 8'hF0;
  localparam logic [7:0] OP_JUMP      = 8'hF0;
  localparam logic [7:0] OP_CALL      = 8'hF1;
  localparam logic [7:0] OP_RETURN    = 8'hF2;
  localparam logic [7:0] OP_REP_MARK  = 8'hF3;
  localparam logic [7:0] OP_REP_END   = 8'hF4;
  localparam logic [7:0] OP_PROGRAM   = 8'hF6;
  localparam logic [7:0] OP_SKIP_ONE  = 8'hF8;
  localparam logic [7:0] OP_TRANSPOSE = 8'hF9;
  localparam logic [7:0] OP_SKIP_VAR  = 8'hFD;
  localparam logic [7:0] OP_STOP_A    = 8'hFE;
  localparam logic [7:0] OP_STOP_B    = 8'hFF;

  // Byte after a note that makes it one byte longer
  localparam logic [7:0] SKIP_MARKER  = 8'hF8;

  // Note numbering
  localparam logic [15:0] NOTE_BASE   = 16'd24;
  localparam logic [15:0] CHAN_BOOST  = 16'd12;

  localparam logic [16:0] DELAY_MAX   = 17'h1FFFF;

  // One input transaction
  typedef struct packed {
    logic        action;
    logic [15:0] start_address;
    logic [7:0]  cmd_byte;
    logic [7:0]  arg_low;
    logic [7:0]  arg_high;
  } msci_item_t;

  // Per-track state, less the call depth
  typedef struct packed {
    logic [15:0] position;
    logic [15:0] repeat_start;
    logic        rep_active;
    logic [7:0]  rep_count;
    logic [15:0] transpose;
    logic [16:0] pending_delay;
    logic [16:0] total_rest;
    logic        first_flag;
    logic [7:0]  instrument;
    logic        ended;
  } msci_state_t;

  // One result transaction
  typedef struct packed {
    logic [15:0]        next_address;
    logic               track_ended;
    logic               note_valid;
    logic signed [15:0] note_number;
    logic [10:0]        note_length;
    logic [16:0]        note_delay;
    logic               first_note;
    logic [7:0]         instrument;
  } msci_result_t;

  // Length in ticks: byte times five
  function automatic logic [10:0] ticks5(input logic [7:0] b);
    ticks5 = {1'b0, b, 2'b00} + {3'b000, b};
  endfunction

  // Saturating add of a tick count onto a 17-bit accumulator
  function automatic logic [16:0] sat_add(input logic [16:0] a, input logic [10:0] b);
    logic [17:0] s;
    s = {1'b0, a} + {7'd0, b};
    sat_add = s[17] ? DELAY_MAX : s[16:0];
  endfunction

endpackage

`default_nettype wire

### rtl/msci_stack.sv
// ----------------------------------------------------------------------------
// msci_stack
// Return address stack: push at the current depth, read below it.
// ----------------------------------------------------------------------------
`default_nettype none

module msci_stack #(
  parameter int STACK_DEPTH = 7
) (
  input  wire                                   clk,
  input  wire                                   push,
  input  wire  [$clog2(STACK_DEPTH + 1) - 1:0]  depth,
  input  wire  [15:0]                           push_data,
  output logic [15:0]                           top_data
);

  localparam int CD_W  = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [15:0]      entries [STACK_DEPTH];
  logic [CD_W-1:0]  below;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;

  assign below  = depth - CD_W'(1);
  assign wr_idx = depth[IDX_W-1:0];
  assign rd_idx = below[IDX_W-1:0];

  // Entries hold no reset value; only written slots are ever popped
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_idx] <= push_data;
    end
  end

  assign top_data = entries[rd_idx];

endmodule

`default_nettype wire

### rtl/msci_step.sv
// ----------------------------------------------------------------------------
// msci_step
// Single-pass command decode: next track state and the result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module msci_step #(
  parameter int STACK_DEPTH   = 7,
  parameter int ADDRESS_LIMIT = 32768,
  parameter int REST_LIMIT    = 110000
) (
  input  msci_pkg::msci_item_t                  item,
  input  msci_pkg::msci_state_t                 st,
  input  wire  [$clog2(STACK_DEPTH + 1) - 1:0]  call_depth,
  input  wire  [15:0]                           stack_top,
  input  wire                                   driver_variant,
  input  wire  [1:0]                            channel_index,
  output msci_pkg::msci_state_t                 st_next,
  output logic [$clog2(STACK_DEPTH + 1) - 1:0]  call_depth_next,
  output logic                                  push,
  output logic [15:0]                           push_data,
  output msci_pkg::msci_result_t                res
);

  import msci_pkg::*;

  localparam int          CD_W      = $clog2(STACK_DEPTH + 1);
  localparam logic [CD_W-1:0] CD_FULL = CD_W'(STACK_DEPTH);
  localparam logic [16:0] ADDR_LIM  = 17'(ADDRESS_LIMIT);
  localparam logic [16:0] REST_LIM  = 17'(REST_LIMIT);

  logic [15:0] target;
  logic [15:0] after_call;
  logic [10:0] ticks;
  logic [7:0]  rep_cnt;
  logic [15:0] note_sum;

  assign target     = st.position + 16'd3 + {item.arg_high, item.arg_low};
  assign after_call = st.position + 16'd3;
  assign ticks      = ticks5(item.arg_low);
  assign rep_cnt    = st.rep_active ? st.rep_count : item.arg_low;
  assign note_sum   = {8'd0, item.cmd_byte} + st.transpose + NOTE_BASE
                    + ((channel_index < 2'd2) ? CHAN_BOOST : 16'd0);
  assign push_data  = after_call;

  always_comb begin
    st_next         = st;
    call_depth_next = call_depth;
    push            = 1'b0;
    res             = '0;

    if (!item.action) begin
      // Track start: clear per-track state, keep instrument, repeat start and repeat count
      st_next.position      = item.start_address;
      call_depth_next       = '0;
      st_next.rep_active    = 1'b0;
      st_next.transpose     = '0;
      st_next.pending_delay = '0;
      st_next.total_rest    = '0;
      st_next.first_flag    = 1'b1;
      st_next.ended         = (item.start_address == 16'd0);
    end else if (!st.ended) begin
      if (item.cmd_byte <= NOTE_MAX) begin
        // Note event
        res.note_valid        = 1'b1;
        res.note_number       = note_sum;
        res.note_length       = ticks;
        res.note_delay        = st.pending_delay;
        res.first_note        = st.first_flag;
        st_next.first_flag    = 1'b0;
        st_next.pending_delay = '0;
        st_next.position      = st.position
                              + ((item.arg_high == SKIP_MARKER) ? 16'd3 : 16'd2);
      end else if (item.cmd_byte == OP_REST) begin
        st_next.pending_delay = sat_add(st.pending_delay, ticks);
        st_next.total_rest    = sat_add(st.total_rest, ticks);
        st_next.position      = st.position + 16'd2;
      end else if (item.cmd_byte < OP_SYS_BASE) begin
        // An opcode above the rest and below the system range ends the track
        st_next.ended = 1'b1;
      end else begin
        unique case (item.cmd_byte) inside
          OP_JUMP: begin
            if (target > st.position) begin
              st_next.position = target;
            end else begin
              st_next.ended = 1'b1;
            end
          end
          OP_CALL: begin
            if (call_depth >= CD_FULL) begin
              st_next.ended = 1'b1;
            end else begin
              push             = 1'b1;
              call_depth_next  = call_depth + CD_W'(1);
              st_next.position = target;
            end
          end
          OP_RETURN: begin
            if (call_depth != '0) begin
              call_depth_next  = call_depth - CD_W'(1);
              st_next.position = stack_top;
            end else begin
              st_next.ended = 1'b1;
            end
          end
          OP_REP_MARK: begin
            st_next.repeat_start = st.position + 16'd1;
            st_next.position     = st.position + 16'd1;
          end
          OP_REP_END: begin
            if (rep_cnt > 8'd1) begin
              st_next.position   = st.repeat_start;
              st_next.rep_active = 1'b1;
              st_next.rep_count  = rep_cnt - 8'd1;
            end else begin
              st_next.rep_active = 1'b0;
              st_next.position   = st.position + 16'd2;
            end
          end
          OP_PROGRAM: begin
            st_next.instrument = item.arg_low;
            st_next.first_flag = 1'b1;
            st_next.position   = st.position + 16'd2;
          end
          OP_TRANSPOSE: begin
            st_next.transpose = st.transpose + {{8{item.arg_low[7]}}, item.arg_low};
            st_next.position  = st.position + 16'd2;
          end
          OP_SKIP_ONE: begin
            st_next.position = st.position + 16'd1;
          end
          OP_SKIP_VAR: begin
            st_next.position = st.position + (driver_variant ? 16'd2 : 16'd1);
          end
          OP_STOP_A, OP_STOP_B: begin
            st_next.ended = 1'b1;
          end
          default: begin
            st_next.position = st.position + 16'd2;
          end
        endcase
      end
    end

    // Address and rest limits, checked after any executed transaction
    if (!item.action || !st.ended) begin
      if ({1'b0, st_next.position} >= ADDR_LIM || st_next.total_rest >= REST_LIM) begin
        st_next.ended = 1'b1;
      end
    end

    res.next_address = st_next.position;
    res.track_ended  = st_next.ended;
    res.instrument   = st_next.instrument;
  end

endmodule

`default_nettype wire

### rtl/music_sequence_command_interpreter.sv
// ----------------------------------------------------------------------------
// music_sequence_command_interpreter
// Executes one track of a sound-driver command stream, one command per cycle while results drain.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  -------   -------------------   -----------------------------------------
//  input     in_valid / in_ready   action, start_address, cmd_byte,
//                                  arg_low, arg_high
//  output    out_valid / out_ready next_address, track_ended, note_valid,
//                                  note_number, note_length, note_delay,
//                                  first_note, instrument
//  config    cfg_write             cfg_index, cfg_data
//
//  Each transaction is captured in the input register and decoded into the
//  result register when that register is free or draining. Throughput is
//  one transaction per cycle while out_ready holds, set by the state update
//  loop (track state feeds the decode of the next command).
//  The input register keeps accepting while a result waits, until it is full.
//  Synchronous reset ends the track and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module music_sequence_command_interpreter #(
  parameter int STACK_DEPTH   = 7,
  parameter int ADDRESS_LIMIT = 32768,
  parameter int REST_LIMIT    = 110000
) (
  input  wire                clk,
  input  wire                rst,
  // configuration
  input  wire                cfg_write,
  input  wire                cfg_index,
  input  wire  [1:0]         cfg_data,
  // input channel
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                action,
  input  wire  [15:0]        start_address,
  input  wire  [7:0]         cmd_byte,
  input  wire  [7:0]         arg_low,
  input  wire  [7:0]         arg_high,
  // output channel
  output logic               out_valid,
  input  wire                out_ready,
  output logic [15:0]        next_address,
  output logic               track_ended,
  output logic               note_valid,
  output logic signed [15:0] note_number,
  output logic [10:0]        note_length,
  output logic [16:0]        note_delay,
  output logic               first_note,
  output logic [7:0]         instrument
);

  import msci_pkg::*;

  localparam int CD_W = $clog2(STACK_DEPTH + 1);

  logic            driver_variant;
  logic [1:0]      channel_index;

  logic            in_q_valid;
  msci_item_t      in_q;
  logic            advance;

  msci_state_t     st;
  msci_state_t     st_next;
  logic [CD_W-1:0] call_depth;
  logic [CD_W-1:0] call_depth_next;
  logic            push;
  logic [15:0]     push_data;
  logic [15:0]     stack_top;
  msci_result_t    res;
  msci_result_t    out_q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      driver_variant <= 1'b0;
      channel_index  <= 2'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_VARIANT: driver_variant <= cfg_data[0];
        CFG_CHANNEL: channel_index  <= cfg_data;
        default:     driver_variant <= driver_variant;
      endcase
    end
  end

  // Handshake: decode fires when the result register is free or draining
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= '{action, start_address, cmd_byte, arg_low, arg_high};
    end
  end

  msci_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .push      (push && advance),
    .depth     (call_depth),
    .push_data (push_data),
    .top_data  (stack_top)
  );

  msci_step #(
    .STACK_DEPTH   (STACK_DEPTH),
    .ADDRESS_LIMIT (ADDRESS_LIMIT),
    .REST_LIMIT    (REST_LIMIT)
  ) u_step (
    .item            (in_q),
    .st              (st),
    .call_depth      (call_depth),
    .stack_top       (stack_top),
    .driver_variant  (driver_variant),
    .channel_index   (channel_index),
    .st_next         (st_next),
    .call_depth_next (call_depth_next),
    .push            (push),
    .push_data       (push_data),
    .res             (res)
  );

  // Track state
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '{position: '0, repeat_start: '0, rep_active: 1'b0, rep_count: '0,
                      transpose: '0, pending_delay: '0, total_rest: '0,
                      first_flag: 1'b1, instrument: '0, ended: 1'b1};
      call_depth <= '0;
    end else if (advance) begin
      st         <= st_next;
      call_depth <= call_depth_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign next_address = out_q.next_address;
  assign track_ended  = out_q.track_ended;
  assign note_valid   = out_q.note_valid;
  assign note_number  = out_q.note_number;
  assign note_length  = out_q.note_length;
  assign note_delay   = out_q.note_delay;
  assign first_note   = out_q.first_note;
  assign instrument   = out_q.instrument;

  // Call depth never exceeds the stack
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    call_depth <= CD_W'(STACK_DEPTH))
    else $error("call depth beyond stack");

  // A command on an ended track changes nothing and plays nothing
  a_ended_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && st.ended && in_q.action) |=>
      (track_ended && !note_valid && next_address == $past(st.position)))
    else $error("ended track advanced");

  // A note consumes the first flag and the pending delay
  a_note_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && res.note_valid) |=> (!st.first_flag && st.pending_delay == '0))
    else $error("note left first flag or delay");

  // With the result register empty the input side is never blocked
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while result register empty");

endmodule

`default_nettype wire
